/* sv/cpwm_pkg.sv */
`default_nettype none
package cpwm_pkg;
    localparam int WIN = 25;
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_GRID  = 8'b00000010,
        S_RD    = 8'b00000100,
        S_CMP   = 8'b00001000,
        S_PICK  = 8'b00010000,
        S_SCAN  = 8'b00100000,
        S_PLACE = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;
    typedef struct packed {
        logic [15:0] bx;
        logic [15:0] by;
        logic [8:0]  pg;
    } t_slot;
endpackage
`default_nettype wire

/* sv/cpwm_ram.sv */
`default_nettype none
module cpwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* sv/clipmap_page_window_manager_unit.sv */
// channel | direction | handshake       | word
// cfg     | in        | valid / ready   | terrain_size
// camera  | in        | valid / stall   | camera_x, camera_z
// place   | out       | valid / stall   | level, block, slot, page, texel
// a camera word passes through every level in turn, then waits out any output
// stall: each changed level's 25 slots pass one at a time (read, compare) through a single
// compare unit over the slot ram, an unchanged level skips the compare.
// after reset all PAGES entries of the free page ram are filled, one entry a cycle,
// before the first camera word is taken. a stalled result holds the unit.
`default_nettype none
module clipmap_page_window_manager_unit #(
    parameter int LEVELS = 11,
    parameter int PAGES  = 275
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [23:0] i_camera_x,
    input  wire logic [23:0] i_camera_z,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_level,
    output logic [15:0]      o_block_x,
    output logic [15:0]      o_block_y,
    output logic [4:0]       o_slot,
    output logic [8:0]       o_page,
    output logic [4:0]       o_table_x,
    output logic [4:0]       o_table_y
);
    import cpwm_pkg::*;
    localparam int SLOTS = LEVELS * WIN;
    localparam int SW = $clog2(SLOTS);
    localparam int PW = $clog2(PAGES);
    localparam int CW = $clog2(PAGES + 1);
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    t_state r_st;
    logic [15:0] r_tsize;
    logic [23:0] r_cx, r_cz;
    logic [LW-1:0] r_lvl;
    logic [4:0] r_i;
    logic [1:0] r_ph;
    logic [LEVELS-1:0] r_known;
    logic [15:0] r_gx [LEVELS];
    logic [15:0] r_gy [LEVELS];
    logic [WIN-1:0] r_pend [LEVELS];
    logic [WIN-1:0] r_held;
    logic [SLOTS-1:0] r_act;
    logic [CW-1:0] r_fc;
    logic r_init;
    logic [CW-1:0] r_icnt;
    logic [4:0] r_j;
    logic [4:0] r_s;
    logic [15:0] r_bx, r_by;

    // slot ram and free page stack
    logic sl_we;
    logic [SW-1:0] sl_wa, sl_ra;
    t_slot sl_wd, sl_rd;
    logic fp_we;
    logic [PW-1:0] fp_wa, fp_ra;
    logic [PW-1:0] fp_wd, fp_rd;

    cpwm_ram #(.WIDTH($bits(t_slot)), .DEPTH(SLOTS)) u_slot (
        .i_clk(i_clk), .i_we(sl_we), .i_waddr(sl_wa), .i_wdata(sl_wd),
        .i_raddr(sl_ra), .o_rdata(sl_rd));
    cpwm_ram #(.WIDTH(PW), .DEPTH(PAGES)) u_free (
        .i_clk(i_clk), .i_we(fp_we), .i_waddr(fp_wa), .i_wdata(fp_wd),
        .i_raddr(fp_ra), .o_rdata(fp_rd));

    logic [SW-1:0] base, sidx;
    assign base = SW'(r_lvl * WIN);
    assign sidx = base + SW'(r_i);

    logic [3:0] lvl4;
    assign lvl4 = 4'(r_lvl);

    // clamp then grid of the current level
    logic [23:0] hi, ccx, ccz;
    logic [40:0] sx, sz;
    logic [15:0] gx, gy;
    assign hi = (r_tsize >= 16'd2) ? {r_tsize - 16'd1, 8'd0} : 24'd256;
    always_comb begin
        ccx = r_cx;
        if (ccx < 24'd256) ccx = 24'd256;
        if (ccx > hi) ccx = hi;
        ccz = r_cz;
        if (ccz < 24'd256) ccz = 24'd256;
        if (ccz > hi) ccz = hi;
        sx = (41'({ccx, 1'b0}) + (41'd256 << r_lvl)) >> r_lvl;
        sz = (41'({ccz, 1'b0}) + (41'd256 << r_lvl)) >> r_lvl;
        gx = sx[24:9];
        gy = sz[24:9];
    end

    logic [15:0] dx, dy;
    logic [4:0] hbit;
    assign dx = sl_rd.bx - (r_gx[r_lvl] - 16'd2);
    assign dy = sl_rd.by - (r_gy[r_lvl] - 16'd2);
    assign hbit = 5'(dy[2:0] * 5 + dx[2:0]);

    // window position j to grid offsets
    logic [2:0] jx, jy;
    always_comb begin
        jy = (r_j >= 5'd20) ? 3'd4 : (r_j >= 5'd15) ? 3'd3 :
             (r_j >= 5'd10) ? 3'd2 : (r_j >= 5'd5) ? 3'd1 : 3'd0;
        jx = 3'(r_j - 5'(jy * 5));
    end
    logic [15:0] nbx, nby;
    assign nbx = r_gx[r_lvl] - 16'd2 + 16'(jx);
    assign nby = r_gy[r_lvl] - 16'd2 + 16'(jy);

    // block mod 5 by reciprocal multiply, exact over 16 bits
    function automatic logic [2:0] mod5(input logic [15:0] v);
        logic [31:0] q;
        logic [15:0] r;
        begin
            q = (32'(v) * 32'd52429) >> 18;
            r = v - 16'(q[15:0] * 16'd5);
            mod5 = r[2:0];
        end
    endfunction

    logic push;
    assign push = (r_st == S_CMP) && r_act[sidx] &&
                  !(dx < 16'd5 && dy < 16'd5) && (r_fc < CW'(PAGES));

    always_comb begin
        sl_we = 1'b0;
        sl_wa = base + SW'(r_s);
        sl_wd = '{bx: r_bx, by: r_by, pg: 9'(fp_rd)};
        sl_ra = sidx;
        fp_we = 1'b0;
        fp_wa = PW'(r_icnt);
        fp_wd = PW'(r_icnt);
        fp_ra = PW'(r_fc - 1'b1);
        if (r_init) begin
            fp_we = 1'b1;
        end else if (push) begin
            fp_we = 1'b1;
            fp_wa = PW'(r_fc);
            fp_wd = PW'(sl_rd.pg);
        end
        if (r_st == S_PLACE && r_ph == 2'd1) sl_we = 1'b1;
    end

    assign o_cfg_ready = (r_st == S_IDLE);
    assign o_stall = (r_st != S_IDLE) || r_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_tsize <= 16'd1024;
            r_known <= '0;
            r_act <= '0;
            r_fc <= CW'(PAGES);
            r_init <= 1'b1;
            r_icnt <= '0;
            o_valid <= 1'b0;
            for (int k = 0; k < LEVELS; k++) begin
                r_pend[k] <= '0;
                r_gx[k] <= '0;
                r_gy[k] <= '0;
            end
        end else begin
            if (r_init) begin
                r_icnt <= r_icnt + 1'b1;
                if (r_icnt == CW'(PAGES - 1)) r_init <= 1'b0;
            end
            if (push) r_fc <= r_fc + 1'b1;
            case (r_st)
                S_IDLE: begin
                    if (i_cfg_valid) r_tsize <= i_cfg_data;
                    if (i_valid && !r_init) begin
                        r_cx <= i_camera_x;
                        r_cz <= i_camera_z;
                        r_lvl <= '0;
                        r_st <= S_GRID;
                    end
                end
                S_GRID: begin
                    r_i <= '0;
                    r_held <= '0;
                    if (r_known[r_lvl] && r_gx[r_lvl] == gx && r_gy[r_lvl] == gy) begin
                        if (r_lvl == LW'(LEVELS - 1)) r_st <= S_PICK;
                        else r_lvl <= r_lvl + 1'b1;
                    end else begin
                        r_known[r_lvl] <= 1'b1;
                        r_gx[r_lvl] <= gx;
                        r_gy[r_lvl] <= gy;
                        r_st <= S_RD;
                    end
                end
                S_RD: r_st <= S_CMP;
                S_CMP: begin
                    if (r_act[sidx]) begin
                        if (dx < 16'd5 && dy < 16'd5) r_held[hbit] <= 1'b1;
                        else r_act[sidx] <= 1'b0;
                    end
                    if (r_i == 5'(WIN - 1)) begin
                        r_st <= S_OUT;
                        r_ph <= 2'd3;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_st <= S_RD;
                    end
                end
                S_PICK: begin
                    if (r_pend[r_lvl] != '0) begin
                        r_j <= '0;
                        r_i <= '0;
                        r_st <= S_SCAN;
                    end else if (r_lvl == '0) begin
                        r_st <= S_IDLE;
                    end else begin
                        r_lvl <= r_lvl - 1'b1;
                    end
                end
                S_SCAN: begin
                    // find lowest pending j, then first free slot
                    if (!r_pend[r_lvl][r_j]) begin
                        r_j <= r_j + 1'b1;
                    end else if (r_act[sidx] && r_i != 5'(WIN - 1)) begin
                        r_i <= r_i + 1'b1;
                    end else if (r_act[sidx] || r_fc == '0) begin
                        r_st <= S_IDLE;
                    end else begin
                        r_s <= r_i;
                        r_bx <= nbx;
                        r_by <= nby;
                        r_ph <= 2'd0;
                        r_st <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    if (r_ph == 2'd1) begin
                        r_fc <= r_fc - 1'b1;
                        r_act[base + SW'(r_s)] <= 1'b1;
                        r_pend[r_lvl][r_j] <= 1'b0;
                        o_level <= lvl4;
                        o_block_x <= r_bx;
                        o_block_y <= r_by;
                        o_slot <= r_s;
                        o_page <= 9'(fp_rd);
                        o_table_x <= 5'(5'(lvl4[1:0]) * 5 + 5'(mod5(r_bx)));
                        o_table_y <= 5'(5'(lvl4 >> 2) * 5 + 5'(mod5(r_by)));
                        o_valid <= 1'b1;
                        r_st <= S_OUT;
                        r_ph <= 2'd0;
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end
                S_OUT: begin
                    if (r_ph == 2'd3) begin
                        // end of a level compare
                        r_pend[r_lvl] <= ~r_held;
                        if (r_lvl == LW'(LEVELS - 1)) r_st <= S_PICK;
                        else begin
                            r_lvl <= r_lvl + 1'b1;
                            r_st <= S_GRID;
                        end
                    end else if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* sv/cpwm_checker.sv */
`default_nettype none
module cpwm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [4:0]  o_slot,
    input wire logic [4:0]  o_table_x,
    input wire logic [4:0]  o_table_y
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_slot))
        else $error("result dropped under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result waits");
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_slot < 5'd25 && o_table_x < 5'd20 && o_table_y < 5'd20)
        else $error("slot or texel out of range");
endmodule
bind clipmap_page_window_manager_unit cpwm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_slot(o_slot),
    .o_table_x(o_table_x), .o_table_y(o_table_y));
`default_nettype wire
